@@ hdl/assert_macros.svh @@
// assertion macros shared by the fader rtl
// expects a clock named clk and an active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RLF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlf assertion failed");

// antecedent implies consequent in the next cycle
`define RLF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlf assertion failed");

`endif

@@ hdl/rlf_pkg.sv @@
// types and constants for the rgb led fader
// used by rlf_muldiv and rgb_led_fader; no dependencies
package rlf_pkg;

  localparam int unsigned COMP_W   = 8;
  localparam int unsigned FADE_W   = 16;
  localparam int unsigned DIM_W    = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEP_CNT_W = $clog2(2 * COMP_W);

  localparam logic [CFG_IDX_W-1:0] REG_FADE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_PERIOD  = 2'd1;

  localparam logic [COMP_W-1:0] FULL_SCALE  = 8'd255;
  localparam logic [COMP_W-1:0] LEVEL_RESET = 8'd100;
  localparam logic [FADE_W-1:0] FADE_RESET  = 16'd10;
  localparam logic [DIM_W-1:0]  DIM_RESET   = 8'd255;
  // duty of green at reset: 255 * 100 / 255
  localparam logic [COMP_W-1:0] DUTY_GREEN_RESET = 8'd100;

  typedef struct packed {
    logic              func;
    logic [COMP_W-1:0] red_in;
    logic [COMP_W-1:0] green_in;
    logic [COMP_W-1:0] blue_in;
    logic              set_brightness;
  } in_t;

  typedef struct packed {
    logic [COMP_W-1:0] pwm_red;
    logic [COMP_W-1:0] pwm_green;
    logic [COMP_W-1:0] pwm_blue;
    logic [COMP_W-1:0] now_red;
    logic [COMP_W-1:0] now_green;
    logic [COMP_W-1:0] now_blue;
    logic [COMP_W-1:0] now_intensity;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

endpackage

@@ hdl/rlf_muldiv.sv @@
// bit-serial multiply then divide lane: q = (a * b) / d
// shift-add multiply, then restoring divide, one bit per cycle; uses rlf_pkg
`include "assert_macros.svh"

module rlf_muldiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rlf_pkg::COMP_W-1:0] a,
  input  logic [rlf_pkg::COMP_W-1:0] b,
  input  logic [rlf_pkg::COMP_W-1:0] d,
  output rlf_pkg::lane_stat_t        stat,
  output logic [rlf_pkg::COMP_W-1:0] q
);

  localparam int unsigned W  = rlf_pkg::COMP_W;
  localparam int unsigned CW = rlf_pkg::STEP_CNT_W;
  localparam logic [CW-1:0] LAST = CW'(2 * W - 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [W-1:0]  mcand;
  logic [W-1:0]  dsor;
  // product in multiply phase; remainder and quotient in divide phase
  logic [2*W-1:0] work;
  logic [2*W-1:0] work_next;
  logic [W:0]     sum;
  logic [W:0]     trial;
  logic [W:0]     diff;

  always_comb begin
    sum   = {1'b0, work[2*W-1:W]} + (work[0] ? {1'b0, mcand} : '0);
    trial = {work[2*W-1:W], work[W-1]};
    diff  = trial - {1'b0, dsor};
    if (!cnt[CW-1]) begin
      work_next = {sum, work[W-1:1]};
    end else if (trial >= {1'b0, dsor}) begin
      work_next = {diff[W-1:0], work[W-2:0], 1'b1};
    end else begin
      work_next = {trial[W-1:0], work[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      dsor  <= d;
      work  <= {{W{1'b0}}, b};
    end else if (busy) begin
      work <= work_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign q         = work[W-1:0];

  `RLF_ASSERT_NEXT(a_start_busy, start, busy && !done)
  `RLF_ASSERT_NEXT(a_last_done, busy && !start && cnt == LAST, done && !busy)
  `RLF_ASSERT_SAME(a_busy_done_excl, busy, !done)

endmodule

@@ hdl/rgb_led_fader.sv @@
// rgb led fader: every item runs through three bit-serial multiply/divide lanes
// (8 multiply steps, 8 divide steps), one item at a time; the result is
// registered into out_data once all lanes are done and the output is free, and
// the next item can be accepted once the result is loaded
// synchronous reset restores periods 10 and 255, colour (0, 255, 0),
// intensity 100, duty (0, 100, 0)
`include "assert_macros.svh"

module rgb_led_fader (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rlf_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rlf_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [rlf_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rlf_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned W  = rlf_pkg::COMP_W;
  localparam int unsigned FW = rlf_pkg::FADE_W;
  localparam int unsigned DW = rlf_pkg::DIM_W;

  function automatic logic [W-1:0] step_toward(input logic [W-1:0] now,
                                               input logic [W-1:0] goal);
    logic [W-1:0] res;
    res = now;
    if (now > goal) begin
      res = now - 1'b1;
    end else if (now < goal) begin
      res = now + 1'b1;
    end
    return res;
  endfunction

  rlf_pkg::state_t state;
  rlf_pkg::state_t state_next;

  logic [FW-1:0] fade_period;
  logic [DW-1:0] dim_period;
  logic [FW-1:0] colour_elapsed;
  logic [DW-1:0] level_elapsed;
  logic [W-1:0]  cur [3];
  logic [W-1:0]  tgt [3];
  logic [W-1:0]  duty [3];
  logic [W-1:0]  level;
  logic [W-1:0]  tgt_level;

  // per-item context held while the lanes run
  logic          op_set;
  logic          op_with_level;
  logic [W-1:0]  op_top;

  logic          accept;
  logic          finish;
  logic [FW-1:0] col_inc;
  logic [DW-1:0] lvl_inc;
  logic          col_step;
  logic          lvl_step;
  logic [W-1:0]  req [3];
  logic [W-1:0]  top;
  logic [W-1:0]  cur_next [3];
  logic [W-1:0]  level_next;
  logic [W-1:0]  lane_a [3];
  logic [W-1:0]  lane_b;
  logic [W-1:0]  lane_d;
  logic [W-1:0]  lane_q [3];
  rlf_pkg::lane_stat_t lane_stat [3];

  // state register and handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    finish     = 1'b0;
    case (state)
      rlf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = rlf_pkg::S_RUN;
        end
      end
      rlf_pkg::S_RUN: begin
        if (lane_stat[0].done && lane_stat[1].done && lane_stat[2].done &&
            (!out_valid || out_ready)) begin
          finish     = 1'b1;
          state_next = rlf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rlf_pkg::S_IDLE;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  // tick arithmetic and lane operand selection
  always_comb begin
    req[0] = in_data.red_in;
    req[1] = in_data.green_in;
    req[2] = in_data.blue_in;
    top = req[0];
    if (req[1] > top) top = req[1];
    if (req[2] > top) top = req[2];

    col_inc  = (colour_elapsed == '1) ? colour_elapsed : colour_elapsed + 1'b1;
    lvl_inc  = (level_elapsed == '1) ? level_elapsed : level_elapsed + 1'b1;
    col_step = col_inc >= fade_period;
    lvl_step = lvl_inc >= dim_period;

    for (int i = 0; i < 3; i++) begin
      cur_next[i] = col_step ? step_toward(cur[i], tgt[i]) : cur[i];
    end
    level_next = lvl_step ? step_toward(level, tgt_level) : level;

    if (in_data.func) begin
      for (int i = 0; i < 3; i++) begin
        lane_a[i] = req[i];
      end
      lane_b = rlf_pkg::FULL_SCALE;
      lane_d = top;
    end else begin
      for (int i = 0; i < 3; i++) begin
        lane_a[i] = cur_next[i];
      end
      lane_b = level_next;
      lane_d = rlf_pkg::FULL_SCALE;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    rlf_muldiv u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (accept),
      .a     (lane_a[g]),
      .b     (lane_b),
      .d     (lane_d),
      .stat  (lane_stat[g]),
      .q     (lane_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_period    <= rlf_pkg::FADE_RESET;
      dim_period     <= rlf_pkg::DIM_RESET;
      colour_elapsed <= '0;
      level_elapsed  <= '0;
      cur[0]         <= '0;
      cur[1]         <= rlf_pkg::FULL_SCALE;
      cur[2]         <= '0;
      tgt[0]         <= '0;
      tgt[1]         <= rlf_pkg::FULL_SCALE;
      tgt[2]         <= '0;
      duty[0]        <= '0;
      duty[1]        <= rlf_pkg::DUTY_GREEN_RESET;
      duty[2]        <= '0;
      level          <= rlf_pkg::LEVEL_RESET;
      tgt_level      <= rlf_pkg::LEVEL_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == rlf_pkg::REG_FADE_PERIOD) begin
        fade_period <= cfg_wdata[FW-1:0];
      end
      if (cfg_we && cfg_addr == rlf_pkg::REG_DIM_PERIOD) begin
        dim_period <= cfg_wdata[DW-1:0];
      end

      // a tick updates the faded values at once; duties follow from the lanes
      if (accept && !in_data.func) begin
        colour_elapsed <= col_step ? '0 : col_inc;
        level_elapsed  <= lvl_step ? '0 : lvl_inc;
        for (int i = 0; i < 3; i++) begin
          cur[i] <= cur_next[i];
        end
        level <= level_next;
      end

      if (finish) begin
        out_valid <= 1'b1;
        if (op_set) begin
          for (int i = 0; i < 3; i++) begin
            // black request divides by zero: force a black target
            tgt[i] <= (op_top == '0) ? '0 : lane_q[i];
          end
          if (op_with_level) begin
            tgt_level <= op_top;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            duty[i] <= lane_q[i];
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_set        <= in_data.func;
      op_with_level <= in_data.set_brightness;
      op_top        <= top;
    end
    if (finish) begin
      out_data.pwm_red       <= op_set ? duty[0] : lane_q[0];
      out_data.pwm_green     <= op_set ? duty[1] : lane_q[1];
      out_data.pwm_blue      <= op_set ? duty[2] : lane_q[2];
      out_data.now_red       <= cur[0];
      out_data.now_green     <= cur[1];
      out_data.now_blue      <= cur[2];
      out_data.now_intensity <= level;
    end
  end

  `RLF_ASSERT_NEXT(a_accept_runs, accept, state == rlf_pkg::S_RUN && lane_stat[0].busy)
  `RLF_ASSERT_NEXT(a_finish_out, finish, out_valid && in_ready)
  `RLF_ASSERT_SAME(a_lanes_lockstep, state == rlf_pkg::S_RUN,
                   lane_stat[0] == lane_stat[1] && lane_stat[1] == lane_stat[2])

endmodule

@@ sim/fader_checker.sv @@
`timescale 1ns / 100ps
// checker for rgb_led_fader: keeps its own copy of the fader state, predicts one
// result per input beat and compares every output beat with the oldest prediction
// depends on rlf_pkg for the beat types, register indexes and reset constants
module fader_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  rlf_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  rlf_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [rlf_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rlf_pkg::CFG_W-1:0]     cfg_wdata,
  output int unsigned                   errors,
  output int unsigned                   pending,
  output int unsigned                   checked
);
  import rlf_pkg::*;

  localparam int unsigned PRINT_CAP = 40;

  logic [COMP_W-1:0] shade_now [3];
  logic [COMP_W-1:0] shade_goal [3];
  logic [COMP_W-1:0] level_now;
  logic [COMP_W-1:0] level_goal;
  logic [FADE_W-1:0] colour_ms;
  logic [FADE_W-1:0] fade_ms;
  logic [DIM_W-1:0]  level_ms;
  logic [DIM_W-1:0]  dim_ms;
  out_t              fader_results_q [$];

  function automatic logic [COMP_W-1:0] nudge(input logic [COMP_W-1:0] now, goal);
    if (now > goal) return now - 1'b1;
    if (now < goal) return now + 1'b1;
    return now;
  endfunction

  function automatic logic [COMP_W-1:0] duty_of(input logic [COMP_W-1:0] c, lvl);
    return COMP_W'((32'(c) * 32'(lvl)) / 32'(FULL_SCALE));
  endfunction

  // applies one beat to the mirrored state and returns what the fader reports
  function automatic out_t advance_fader(input in_t beat);
    logic [COMP_W-1:0] ask [3];
    logic [COMP_W-1:0] top;
    out_t              res;
    if (beat.func) begin
      ask[0] = beat.red_in;
      ask[1] = beat.green_in;
      ask[2] = beat.blue_in;
      top = ask[0];
      if (ask[1] > top) top = ask[1];
      if (ask[2] > top) top = ask[2];
      // black request gives a black target instead of dividing by zero
      for (int i = 0; i < 3; i++)
        shade_goal[i] = (top == '0) ? '0
                      : COMP_W'((32'(ask[i]) * 32'(FULL_SCALE)) / 32'(top));
      if (beat.set_brightness) level_goal = top;
    end else begin
      // counters saturate, then step and clear once they reach the period
      if (colour_ms != '1) colour_ms = colour_ms + 1'b1;
      if (colour_ms >= fade_ms) begin
        for (int i = 0; i < 3; i++) shade_now[i] = nudge(shade_now[i], shade_goal[i]);
        colour_ms = '0;
      end
      if (level_ms != '1) level_ms = level_ms + 1'b1;
      if (level_ms >= dim_ms) begin
        level_now = nudge(level_now, level_goal);
        level_ms = '0;
      end
    end
    res.pwm_red       = duty_of(shade_now[0], level_now);
    res.pwm_green     = duty_of(shade_now[1], level_now);
    res.pwm_blue      = duty_of(shade_now[2], level_now);
    res.now_red       = shade_now[0];
    res.now_green     = shade_now[1];
    res.now_blue      = shade_now[2];
    res.now_intensity = level_now;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch: %s (at %0t)", what, $time);
  endtask

  task automatic check_field(input string name, input logic [COMP_W-1:0] got, want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d", checked, name, got, want));
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      shade_now[0]  = '0;
      shade_now[1]  = FULL_SCALE;
      shade_now[2]  = '0;
      shade_goal[0] = '0;
      shade_goal[1] = FULL_SCALE;
      shade_goal[2] = '0;
      level_now     = LEVEL_RESET;
      level_goal    = LEVEL_RESET;
      colour_ms     = '0;
      level_ms      = '0;
      fade_ms       = FADE_RESET;
      dim_ms        = DIM_RESET;
      fader_results_q.delete();
      errors  = 0;
      checked = 0;
    end else begin
      // writes to an unused index fall through and change nothing
      if (cfg_we) begin
        case (cfg_addr)
          REG_FADE_PERIOD: fade_ms = cfg_wdata[FADE_W-1:0];
          REG_DIM_PERIOD:  dim_ms  = cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) fader_results_q.push_back(advance_fader(in_data));
      if (out_valid && out_ready) begin
        if (fader_results_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing outstanding: %h", out_data));
        end else begin
          want = fader_results_q.pop_front();
          check_field("pwm_red", out_data.pwm_red, want.pwm_red);
          check_field("pwm_green", out_data.pwm_green, want.pwm_green);
          check_field("pwm_blue", out_data.pwm_blue, want.pwm_blue);
          check_field("now_red", out_data.now_red, want.now_red);
          check_field("now_green", out_data.now_green, want.now_green);
          check_field("now_blue", out_data.now_blue, want.now_blue);
          check_field("now_intensity", out_data.now_intensity, want.now_intensity);
        end
        checked++;
      end
    end
    pending <= fader_results_q.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// top of the rgb_led_fader testbench: clock, reset, register setups and beat traffic
// depends on rlf_pkg, rgb_led_fader and fader_checker (which does all the checking)
module tb;
  import rlf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PHASE_BEATS  = 135;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_reqs    = 0;
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ticks_sent   = 0;
  int unsigned colour_reqs  = 0;
  int unsigned setups       = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rgb_led_fader dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  fader_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  // result side: random stalls, plus a long hold-off whenever one is requested
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_reqs) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken,
  // with valid still high so back-to-back beats need no gap
  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (beat.func) colour_reqs++;
    else ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup(input logic [FADE_W-1:0] fade, input logic [DIM_W-1:0] dim);
    drain();
    repeat (2) @(negedge clk);
    write_reg(REG_FADE_PERIOD, fade);
    write_reg(REG_DIM_PERIOD, CFG_W'(dim));
    setups++;
  endtask

  function automatic in_t colour_beat(input logic [COMP_W-1:0] r, g, b, input logic lvl);
    in_t beat;
    beat.func           = 1'b1;
    beat.red_in         = r;
    beat.green_in       = g;
    beat.blue_in        = b;
    beat.set_brightness = lvl;
    return beat;
  endfunction

  // ticks carry random don't-care fields too, so every input bit toggles
  function automatic in_t random_beat(input int unsigned request_pct);
    in_t         beat;
    int unsigned pick;
    beat = $bits(in_t)'($urandom);
    beat.func = ($urandom_range(99) < request_pct);
    if (beat.func) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        beat.red_in   = '0;
        beat.green_in = '0;
        beat.blue_in  = '0;
      end else if (pick < 3) begin
        beat.red_in   = COMP_W'($urandom_range(3));
        beat.green_in = COMP_W'($urandom_range(3));
        beat.blue_in  = COMP_W'($urandom_range(3));
      end else if (pick == 3) begin
        beat.red_in = FULL_SCALE;
      end
    end
    return beat;
  endfunction

  task automatic run_phase(input logic [FADE_W-1:0] fade, input logic [DIM_W-1:0] dim,
                           input int unsigned idle, stall, request_pct,
                           input bit hold, pause);
    setup(fade, dim);
    idle_pct  = idle;
    stall_pct = stall;
    // receiver holds off while beats keep coming, so the input side backs up
    if (hold) hold_reqs++;
    for (int n = 0; n < PHASE_BEATS; n++) begin
      if (pause && n == PHASE_BEATS / 2) drain();
      send_beat(random_beat(request_pct));
    end
  endtask

  initial begin
    in_t beat;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: long periods, so ticks only report the reset colour
    beat = random_beat(0);
    send_beat(beat);
    send_beat(random_beat(0));
    send_beat(colour_beat(8'd255, 8'd255, 8'd255, 1'b1));
    // black request, once keeping and once clearing the intensity target
    send_beat(colour_beat(8'd0, 8'd0, 8'd0, 1'b0));
    send_beat(colour_beat(8'd0, 8'd0, 8'd0, 1'b1));
    send_beat(colour_beat(8'd1, 8'd0, 8'd0, 1'b0));
    send_beat(colour_beat(8'd0, 8'd0, 8'd1, 1'b1));
    send_beat(colour_beat(8'd200, 8'd100, 8'd7, 1'b0));
    send_beat(colour_beat(8'd3, 8'd255, 8'd128, 1'b1));

    // zero periods step on every tick; the spare index must change nothing
    setup('0, '0);
    write_reg(REG_SPARE, '1);
    repeat (6) send_beat(random_beat(0));
    send_beat(colour_beat(8'd255, 8'd0, 8'd255, 1'b1));
    repeat (4) send_beat(random_beat(0));

    setup('1, '1);
    repeat (2) send_beat(random_beat(0));

    run_phase(16'd1, 8'd1, 0, 0, 10, 1'b0, 1'b0);
    run_phase(16'd0, 8'd0, 70, 0, 3, 1'b0, 1'b1);
    run_phase(16'd2, 8'd3, 0, 70, 15, 1'b1, 1'b0);
    run_phase(16'd40, 8'd30, 17, 17, 10, 1'b0, 1'b0);
    // shorter periods than the counts already reached: step on the next tick
    run_phase(16'd3, 8'd2, 0, 0, 8, 1'b0, 1'b0);
    run_phase(16'hFFFF, 8'hFF, 0, 0, 20, 1'b0, 1'b0);
    run_phase(FADE_W'($urandom_range(7)), DIM_W'($urandom_range(7)), 17, 17, 5, 1'b1, 1'b1);
    run_phase(16'd0, 8'd5, 70, 0, 12, 1'b0, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d ticks and %0d colour requests over %0d register setups",
             ticks_sent, colour_reqs, setups);
    $display("compared %0d result beats, %0d field mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
